FILE: hdl/scgz_pkg.sv
// Shared types and constants for the Scharr gradient block with zero mask.
// Used by the line store, the gradient kernel, the result sequencer and the top level.
// No dependencies.
package scgz_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int PIXEL_BITS = 16;

  // Fixed port widths
  localparam int PIX_IN_W   = 16;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int GRAD_OUT_W = 21;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WDIM_W = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;
  localparam int GRAD_W = PIXEL_BITS + 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef pixel_t [2:0][2:0]     win_t;   // [row top..bottom][column left..right]

  // Position flags of one pixel, carried from the counters to the sequencer
  typedef struct packed {
    logic emit;      // row >= 1 and column >= 1
    logic row_one;   // row == 1: top row mirrors to the bottom
    logic col_one;   // column == 1: left column mirrors to the right
    logic last_row;  // row == height-1
    logic last_col;  // column == width-1
  } pos_flags_t;

endpackage

FILE: hdl/scgz_line_store.sv
// Two row line stores (previous row, row before it) in synchronous RAM.
// Reads are registered; a write to the address read in the same cycle is forwarded.
// Depends on scgz_pkg.
module scgz_line_store
  import scgz_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   rd_en,
  input  col_t   rd_addr,
  input  logic   wr_en,
  input  col_t   wr_addr,
  input  pixel_t wr_a,
  input  pixel_t wr_b,
  output pixel_t up1,
  output pixel_t up2
);

  pixel_t mem_a [MAX_WIDTH];
  pixel_t mem_b [MAX_WIDTH];

  pixel_t rd_a;
  pixel_t rd_b;
  pixel_t fwd_a;
  pixel_t fwd_b;
  logic   fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    if (rd_en) begin
      rd_a  <= mem_a[rd_addr];
      rd_b  <= mem_b[rd_addr];
      fwd_a <= wr_a;
      fwd_b <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign up1 = fwd ? fwd_a : rd_a;
  assign up2 = fwd ? fwd_b : rd_b;

endmodule

FILE: hdl/scgz_grad.sv
// Scharr 3x3 kernel (weights 3,10,3) on one picked window, with zero detect.
// Purely combinational. Depends on scgz_pkg.
module scgz_grad
  import scgz_pkg::*;
(
  input  win_t                     p,
  output logic signed [GRAD_W-1:0] gx,
  output logic signed [GRAD_W-1:0] gy,
  output logic                     zero
);

  logic signed [PIXEL_BITS:0]   dx_n [3];
  logic signed [PIXEL_BITS:0]   dy_n [3];
  logic signed [GRAD_W-1:0]     dx [3];
  logic signed [GRAD_W-1:0]     dy [3];
  logic signed [GRAD_W-1:0]     sx_side;
  logic signed [GRAD_W-1:0]     sy_side;

  always_comb begin
    zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (p[i][j] == '0) zero = 1'b1;
      end
      dx_n[i] = $signed({1'b0, p[i][2]}) - $signed({1'b0, p[i][0]});
      dy_n[i] = $signed({1'b0, p[2][i]}) - $signed({1'b0, p[0][i]});
      dx[i]   = GRAD_W'(dx_n[i]);
      dy[i]   = GRAD_W'(dy_n[i]);
    end
    // 3*(outer sum) + 10*centre, by shift and add
    sx_side = dx[0] + dx[2];
    sy_side = dy[0] + dy[2];
    gx = (sx_side <<< 1) + sx_side + (dx[1] <<< 3) + (dx[1] <<< 1);
    gy = (sy_side <<< 1) + sy_side + (dy[1] <<< 3) + (dy[1] <<< 1);
  end

endmodule

FILE: hdl/scgz_emit.sv
// Window registers and result sequencer: up to four results per pixel, one per cycle while
// out_stall is low, into an output register. Depends on scgz_pkg and scgz_grad.
module scgz_emit
  import scgz_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  pixel_t                       up2,
  input  pixel_t                       up1,
  input  pixel_t                       pix,
  input  pos_flags_t                   flags,
  output logic                         ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [GRAD_OUT_W-1:0] grad_x,
  output logic signed [GRAD_OUT_W-1:0] grad_y,
  output logic                         masked,
  output logic                         last_of_run,
  output logic                         frame_end
);

  win_t       win;
  pos_flags_t cur;
  logic [3:0] pending;   // slots: upper/mid, lower/mid, upper/end, lower/end
  logic [3:0] pick;
  logic [3:0] rest;
  logic [3:0] pend_next;
  logic       out_free;
  logic       emitting;
  logic       lo;
  logic       fin;
  logic [1:0] rsel [3];
  logic [1:0] csel [3];
  win_t       sel;

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic                     zero;

  assign out_free = !out_valid || !out_stall;
  assign emitting = out_free && (pending != 4'b0000);
  assign pick     = pending & (~pending + 4'd1);
  assign rest     = pending & ~pick;
  assign ready    = (pending == 4'b0000) || (emitting && (rest == 4'b0000));

  assign pend_next = flags.emit ?
                     {flags.last_row & flags.last_col, flags.last_col, flags.last_row, 1'b1} :
                     4'b0000;

  // Pick rows and columns of the window with mirror borders
  always_comb begin
    lo  = pick[1] | pick[3];
    fin = pick[2] | pick[3];
    rsel[0] = lo ? 2'd1 : (cur.row_one ? 2'd2 : 2'd0);
    rsel[1] = lo ? 2'd2 : 2'd1;
    rsel[2] = lo ? 2'd1 : 2'd2;
    csel[0] = fin ? 2'd1 : (cur.col_one ? 2'd2 : 2'd0);
    csel[1] = fin ? 2'd2 : 2'd1;
    csel[2] = fin ? 2'd1 : 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sel[i][j] = win[rsel[i]][csel[j]];
      end
    end
  end

  scgz_grad u_grad (
    .p    (sel),
    .gx   (gx),
    .gy   (gy),
    .zero (zero)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      pending   <= 4'b0000;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up2;
        win[1][2] <= up1;
        win[2][2] <= pix;
        pending   <= pend_next;
      end else if (emitting) begin
        pending <= rest;
      end
      if (out_free) begin
        out_valid <= emitting;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= flags;
    end
    if (emitting) begin
      grad_x      <= zero ? '0 : GRAD_OUT_W'(gx);
      grad_y      <= zero ? '0 : GRAD_OUT_W'(gy);
      masked      <= zero;
      last_of_run <= (rest == 4'b0000);
      frame_end   <= pick[3];
    end
  end

endmodule

FILE: hdl/scharr_gradient_zero_mask_top.sv
// Top level of the streaming Scharr gradient with zero-neighbourhood mask.
// Depends on scgz_pkg, scgz_line_store, scgz_emit (and scgz_grad below it).
//
//   port group   direction  handshake               payload
//   input beat   in         in_valid / in_stall     pixel_value, frame_start
//   result beat  out        out_valid / out_stall   grad_x, grad_y, masked,
//                                                   last_of_run, frame_end
//   config       in         cfg_write_en            cfg_index, cfg_data
//
// Cycles: one pixel beat per clock while in_stall is low. From the second row on a pixel
// gives one result (none at column 0), the last pixel of a row two, and each pixel of the
// last row two (four at its end), one result per clock while out_stall is low; the result
// sequencer holds further pixel beats back until a pixel's last result goes out.
// Path: an accepted pixel passes the memory stage, then the window registers and the
// sequencer, then the output register (out_valid high).
// Reset: synchronous; clears counters, window and pipeline valids; line stores are
// not cleared (entries are always written before any emitted result reads them).
// Stalls: out_stall holds the output register; the sequencer, then the memory stage,
// then in_stall back up behind it; no beat is dropped.
module scharr_gradient_zero_mask_top
  import scgz_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [PIX_IN_W-1:0]          pixel_value,
  input  logic                         frame_start,
  // results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [GRAD_OUT_W-1:0] grad_x,
  output logic signed [GRAD_OUT_W-1:0] grad_y,
  output logic                         masked,
  output logic                         last_of_run,
  output logic                         frame_end
);

  // Size registers, raw as written
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // Used sizes, saturated into [2, MAX]
  logic [WDIM_W-1:0] w_used;
  logic [HDIM_W-1:0] h_used;

  // Position of the next pixel
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;

  // Position of the pixel being accepted
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [HDIM_W-1:0] row_pre;
  logic [WDIM_W-1:0] col_inc;
  logic [HDIM_W-1:0] row_inc;
  pos_flags_t        flags_cur;

  // Memory read stage
  logic       s1_valid;
  col_t       s1_col;
  pixel_t     s1_pix;
  pos_flags_t s1_flags;
  logic       s1_advance;
  logic       s1_free;
  logic       accept;

  pixel_t up1;
  pixel_t up2;
  logic   emit_ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(MAX_WIDTH);
      frame_height <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_write_en) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  always_comb begin
    if (32'(frame_width) < 32'd2) begin
      w_used = WDIM_W'(2);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_used = WDIM_W'(MAX_WIDTH);
    end else begin
      w_used = WDIM_W'(frame_width);
    end
    if (32'(frame_height) < 32'd2) begin
      h_used = HDIM_W'(2);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_used = HDIM_W'(MAX_HEIGHT);
    end else begin
      h_used = HDIM_W'(frame_height);
    end
  end

  // Position of this pixel: frame_start restarts the plane; a shrunken size
  // pushes the pixel to the next row, or back to row 0
  always_comb begin
    if (frame_start) begin
      col_cur = '0;
      row_pre = '0;
    end else if ({1'b0, column_count} >= w_used) begin
      col_cur = '0;
      row_pre = {1'b0, row_count} + HDIM_W'(1);
    end else begin
      col_cur = column_count;
      row_pre = {1'b0, row_count};
    end
    row_cur = (row_pre >= h_used) ? '0 : row_pre[ROW_W-1:0];

    col_inc = {1'b0, col_cur} + WDIM_W'(1);
    row_inc = {1'b0, row_cur} + HDIM_W'(1);
    if (col_inc >= w_used) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= h_used) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_cur;
    end

    flags_cur.emit     = (row_cur != '0) && (col_cur != '0);
    flags_cur.row_one  = (row_cur == ROW_W'(1));
    flags_cur.col_one  = (col_cur == COL_W'(1));
    flags_cur.last_row = ({1'b0, row_cur} == h_used - HDIM_W'(1));
    flags_cur.last_col = ({1'b0, col_cur} == w_used - WDIM_W'(1));
  end

  // Handshake: memory stage moves on when the sequencer takes it
  assign s1_advance = s1_valid && emit_ready;
  assign s1_free    = !s1_valid || s1_advance;
  assign in_stall   = !s1_free;
  assign accept     = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (s1_free) begin
        s1_valid <= accept;
      end
    end
  end

  // Payload of the memory stage: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_cur;
      s1_pix   <= pixel_value[PIXEL_BITS-1:0];
      s1_flags <= flags_cur;
    end
  end

  // Read both rows above at accept; shift them down on the way out
  scgz_line_store u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .wr_en   (s1_advance),
    .wr_addr (s1_col),
    .wr_a    (s1_pix),
    .wr_b    (up1),
    .up1     (up1),
    .up2     (up2)
  );

  scgz_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_advance),
    .up2         (up2),
    .up1         (up1),
    .pix         (s1_pix),
    .flags       (s1_flags),
    .ready       (emit_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .masked      (masked),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

  // A masked result carries zero gradients
  assert property (@(posedge clk) disable iff (rst)
    out_valid && masked |-> (grad_x == '0) && (grad_y == '0))
    else $error("masked result with nonzero gradient");

  // The final result of a plane also closes its run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_run)
    else $error("frame end without last of run");

  // A held memory stage keeps its column and pixel
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_col) && $stable(s1_pix))
    else $error("memory stage changed while held");

  // No new read while the memory stage holds an item it cannot pass on
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !emit_ready |-> !accept)
    else $error("accept into busy memory stage");

endmodule

FILE: tb/scharr_gradient_zero_mask_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for scharr_gradient_zero_mask_top: random pixel planes in, Scharr
// gradient beats checked against an in-bench line-buffer predictor. Depends on scgz_pkg
// and the block's RTL only.
module scharr_gradient_zero_mask_top_test;
  import scgz_pkg::*;

  // One pending pixel beat
  typedef struct {
    logic [PIX_IN_W-1:0] pix;
    logic                fs;
  } pixel_beat_t;

  // One gradient result beat
  typedef struct {
    logic signed [GRAD_OUT_W-1:0] grad_x;
    logic signed [GRAD_OUT_W-1:0] grad_y;
    logic                         masked;
    logic                         last_of_run;
    logic                         frame_end;
  } grad_beat_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]             cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [PIX_IN_W-1:0]          pixel_value = '0;
  logic                         frame_start = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [GRAD_OUT_W-1:0] grad_x;
  logic signed [GRAD_OUT_W-1:0] grad_y;
  logic                         masked;
  logic                         last_of_run;
  logic                         frame_end;

  // Predictor state: two line buffers, the 3x3 window and the raster position.
  // Line buffers start at zero; entries never written only feed results that are
  // never emitted, so their start value does not matter.
  bit [PIXEL_BITS-1:0] line_above [MAX_WIDTH];
  bit [PIXEL_BITS-1:0] line_two_above [MAX_WIDTH];
  bit [PIXEL_BITS-1:0] window_px [9];          // [row*3 + col], row 0 = oldest line
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;
  logic [CFG_W-1:0]    width_reg = CFG_W'(MAX_WIDTH);
  logic [CFG_W-1:0]    height_reg = CFG_W'(MAX_HEIGHT);

  pixel_beat_t pixel_feed [$];                 // beats waiting for the driver
  grad_beat_t  expected_grads [$];             // gradients predicted, not yet seen
  pixel_beat_t next_beat;
  grad_beat_t  want;

  bit steady = 1'b0;                           // suppress all idling on both sides
  bit pixel_taken = 1'b0;                      // in beat accepted at the last rising edge
  int mismatches = 0;
  int pixels_fed = 0;
  int planes_opened = 0;
  int results_seen = 0;
  int masked_seen = 0;
  int plane_ends_seen = 0;
  int settings_used = 0;

  scharr_gradient_zero_mask_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_value  (pixel_value),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .masked       (masked),
    .last_of_run  (last_of_run),
    .frame_end    (frame_end)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturate a size register into [2, top]
  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  // Gradient over the window rows t/m/b and columns l/c/r; a border mirrors by
  // repeating an inner index. Any zero in the chosen 3x3 masks the pair.
  function automatic grad_beat_t gradient_at(int t, int m, int b, int l, int c, int r);
    int         rows [3];
    int         cols [3];
    int         wt [3];
    int         gx;
    int         gy;
    int         i;
    int         j;
    bit         hit_zero;
    grad_beat_t g;
    rows = '{t, m, b};
    cols = '{l, c, r};
    wt = '{3, 10, 3};
    gx = 0;
    gy = 0;
    hit_zero = 1'b0;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        if (window_px[rows[i]*3 + cols[j]] == 0) hit_zero = 1'b1;
    for (i = 0; i < 3; i++) begin
      gx += wt[i] * (int'(window_px[rows[i]*3 + cols[2]]) - int'(window_px[rows[i]*3 + cols[0]]));
      gy += wt[i] * (int'(window_px[rows[2]*3 + cols[i]]) - int'(window_px[rows[0]*3 + cols[i]]));
    end
    g.grad_x = hit_zero ? '0 : GRAD_OUT_W'(gx);
    g.grad_y = hit_zero ? '0 : GRAD_OUT_W'(gy);
    g.masked = hit_zero;
    g.last_of_run = 1'b0;
    g.frame_end = 1'b0;
    return g;
  endfunction

  // Advance the raster position by one accepted pixel and queue the gradients it releases
  task automatic predict_gradients(logic [PIX_IN_W-1:0] pix_in, logic fs);
    int unsigned         w;
    int unsigned         h;
    int unsigned         c;
    int unsigned         r;
    int                  top_row;
    int                  left_col;
    int                  k;
    bit                  bottom;
    bit                  closes_plane;
    bit [PIXEL_BITS-1:0] pix;
    bit [PIXEL_BITS-1:0] up1;
    bit [PIXEL_BITS-1:0] up2;
    grad_beat_t          run [$];
    grad_beat_t          g;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    pix = pix_in[PIXEL_BITS-1:0];
    closes_plane = 1'b0;

    // A frame start restarts the plane; otherwise a stale position (after a size
    // change) moves to the next row, or wraps to row 0.
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
    end
    c = col_pos;
    r = row_pos;

    up1 = line_above[c];
    up2 = line_two_above[c];
    line_two_above[c] = up1;
    line_above[c] = pix;
    for (k = 0; k < 3; k++) begin
      window_px[k*3]     = window_px[k*3 + 1];
      window_px[k*3 + 1] = window_px[k*3 + 2];
    end
    window_px[2] = up2;
    window_px[5] = up1;
    window_px[8] = pix;

    if (r >= 1 && c >= 1) begin
      bottom   = (r == h - 1);
      top_row  = (r == 1) ? 2 : 0;
      left_col = (c == 1) ? 2 : 0;
      // pixel one row up and one column left, then its last-row twin
      run.push_back(gradient_at(top_row, 1, 2, left_col, 1, 2));
      if (bottom) run.push_back(gradient_at(1, 2, 1, left_col, 1, 2));
      // right edge: flush the last column as well
      if (c == w - 1) begin
        run.push_back(gradient_at(top_row, 1, 2, 1, 2, 1));
        if (bottom) begin
          run.push_back(gradient_at(1, 2, 1, 1, 2, 1));
          closes_plane = 1'b1;
        end
      end
      for (k = 0; k < run.size(); k++) begin
        g = run[k];
        g.last_of_run = (k == run.size() - 1);
        g.frame_end = closes_plane && (k == run.size() - 1);
        expected_grads.push_back(g);
      end
    end

    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------

  task automatic compare_field(string name, logic signed [31:0] exp_v, logic signed [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pixel_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      // check the result beat first: this edge's pixel cannot produce it
      if (out_valid && !out_stall) begin
        results_seen++;
        if (masked) masked_seen++;
        if (frame_end) plane_ends_seen++;
        if (expected_grads.size() == 0) begin
          $error("unexpected result beat: grad_x %0d, grad_y %0d", grad_x, grad_y);
          mismatches++;
        end else begin
          want = expected_grads.pop_front();
          compare_field("grad_x", want.grad_x, grad_x);
          compare_field("grad_y", want.grad_y, grad_y);
          compare_field("masked", want.masked, masked);
          compare_field("last_of_run", want.last_of_run, last_of_run);
          compare_field("frame_end", want.frame_end, frame_end);
        end
      end
      if (in_valid && !in_stall) begin
        pixels_fed++;
        predict_gradients(pixel_value, frame_start);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      // hold a stalled beat; otherwise advance to the next one or idle about 11% of the time
      if (!in_valid || pixel_taken) begin
        if (pixel_feed.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
          next_beat = pixel_feed.pop_front();
          in_valid    <= 1'b1;
          pixel_value <= next_beat.pix;
          frame_start <= next_beat.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // back-pressure the result side about 11% of the time
      out_stall <= !steady && ($urandom_range(99) < 11);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one size register; the block is idle whenever this is called
  task automatic set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic add_pixel(logic [PIX_IN_W-1:0] p, bit fs);
    pixel_beat_t b;
    b.pix = p;
    b.fs  = fs;
    if (fs) planes_opened++;
    pixel_feed.push_back(b);
  endtask

  // Mix of zeros (they drive the mask), full scale, tiny and arbitrary values
  function automatic logic [PIX_IN_W-1:0] pick_pixel(int zero_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < zero_pct) return '0;
    if (roll < zero_pct + 6) return '1;
    if (roll < zero_pct + 12) return PIX_IN_W'($urandom_range(1, 15));
    return PIX_IN_W'($urandom_range(1, 65535));
  endfunction

  // Queue n pixels; the first opens a plane if asked, and any may carry a stray frame start
  task automatic queue_pixels(int unsigned n, bit open_plane, int zero_pct, int fs_pct);
    int unsigned k;
    for (k = 0; k < n; k++)
      add_pixel(pick_pixel(zero_pct), (k == 0 && open_plane) || ($urandom_range(99) < fs_pct));
  endtask

  // Drain: wait until every queued pixel went in and every gradient came out, then let
  // the pipeline settle, since the last pixels may release no result at all
  task automatic wait_quiet();
    do @(posedge clk);
    while (pixel_feed.size() != 0 || in_valid || expected_grads.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned      w;
    int unsigned      h;
    int unsigned      n;
    int unsigned      random_pixels;
    int               phase;
    int               planes;
    int               kind;
    int               zero_pct;
    int               fs_pct;
    bit               whole;
    bit               opened;
    bit               big;
    logic [CFG_W-1:0] wcfg;
    logic [CFG_W-1:0] hcfg;
    random_pixels = 0;
    phase = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: 2x2 planes from below-range sizes (both clamp up to 2)
    set_size(REG_FRAME_WIDTH, CFG_W'(1));
    set_size(REG_FRAME_HEIGHT, CFG_W'(0));
    settings_used++;
    @(posedge clk);
    // full-scale against one: largest unmasked gradients, last row drains four results
    add_pixel(16'hFFFF, 1'b1);
    add_pixel(16'h0001, 1'b0);
    add_pixel(16'h0001, 1'b0);
    add_pixel(16'hFFFF, 1'b0);
    // no frame start: position wraps into a new plane; the zero masks everything
    add_pixel(16'h0007, 1'b0);
    add_pixel(16'h0000, 1'b0);
    add_pixel(16'hFFFF, 1'b0);
    add_pixel(16'h0003, 1'b0);
    // abandon a plane after three pixels with an early frame start
    add_pixel(16'h0005, 1'b1);
    add_pixel(16'h0009, 1'b0);
    add_pixel(16'h000B, 1'b0);
    add_pixel(16'h8000, 1'b1);
    add_pixel(16'h7FFF, 1'b0);
    add_pixel(16'h00FF, 1'b0);
    add_pixel(16'hFF00, 1'b0);
    wait_quiet();

    // Directed: shrink the size in the middle of a 4x4 plane
    set_size(REG_FRAME_WIDTH, CFG_W'(4));
    set_size(REG_FRAME_HEIGHT, CFG_W'(4));
    settings_used++;
    @(posedge clk);
    add_pixel(pick_pixel(0), 1'b1);
    queue_pixels(9, 1'b0, 0, 0);                // stop at row 2, column 2
    wait_quiet();
    set_size(REG_FRAME_WIDTH, CFG_W'(2));       // column past the width: jump to row 3
    settings_used++;
    @(posedge clk);
    queue_pixels(1, 1'b0, 0, 0);
    wait_quiet();
    set_size(REG_FRAME_HEIGHT, CFG_W'(3));      // row past the height: back to row 0
    settings_used++;
    @(posedge clk);
    queue_pixels(5, 1'b0, 0, 0);
    wait_quiet();

    // Random phases: new sizes, then a few planes; the sender pauses at the end of
    // each phase until every gradient is back. Phase 1 opens the widest plane (4095
    // saturates to 2048) and phase 4 the tallest; both are cut short and run with no
    // idling at all, phase 4 as a long unbroken stretch.
    while (random_pixels < 350) begin
      big = (phase == 1) || (phase == 4);
      if (phase == 1) begin
        wcfg = '1;
        hcfg = CFG_W'(2);
      end else if (phase == 4) begin
        wcfg = CFG_W'(2);
        hcfg = CFG_W'(MAX_HEIGHT);
      end else begin
        wcfg = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 9));
        hcfg = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 6));
      end
      set_size(REG_FRAME_WIDTH, wcfg);
      set_size(REG_FRAME_HEIGHT, hcfg);
      settings_used++;
      w = clamp_dim(wcfg, MAX_WIDTH);
      h = clamp_dim(hcfg, MAX_HEIGHT);
      @(posedge clk);
      steady = big;
      whole = 1'b0;
      planes = big ? 1 : $urandom_range(1, 4);
      repeat (planes) begin
        kind = $urandom_range(99);
        case ($urandom_range(2))
          0: zero_pct = 0;
          1: zero_pct = 2;
          default: zero_pct = 10;
        endcase
        if (big) begin
          // open the wide or tall plane and cut it short; the next phase reopens
          n = (phase == 1) ? $urandom_range(24, 40) : $urandom_range(100, 140);
          opened = 1'b1;
          fs_pct = 0;
          whole = 1'b0;
        end else if (kind < 70) begin
          // well-formed plane; after a complete one, sometimes rely on the wrap
          n = w * h;
          opened = !(whole && $urandom_range(2) == 0);
          fs_pct = 0;
          whole = 1'b1;
        end else if (kind < 85) begin
          // cut short; the next plane opens with a frame start
          n = $urandom_range(1, w * h - 1);
          opened = 1'b1;
          fs_pct = 0;
          whole = 1'b0;
        end else begin
          // noise: stray frame starts anywhere
          n = $urandom_range(1, 2 * w * h);
          opened = 1'b1;
          fs_pct = 6;
          whole = 1'b0;
        end
        queue_pixels(n, opened, zero_pct, fs_pct);
        random_pixels += n;
      end
      wait_quiet();
      phase++;
    end
    steady = 1'b0;

    $display("Covered %0d pixel beats, %0d frame starts, %0d size settings (2x2 to 2048 wide/high).",
             pixels_fed, planes_opened, settings_used);
    $display("Checked %0d gradient beats: %0d masked, %0d plane ends, %0d mismatches.",
             results_seen, masked_seen, plane_ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
